/* hdl/sdhr_pkg.sv */
// sdhr_pkg: shared types and constants for the switch debounce block
// transaction payload structs, event codes, register indexes, controller states
// no dependencies
package sdhr_pkg;

	typedef struct packed {
		logic        func;
		logic [7:0]  down_mask;
		logic [31:0] now_us;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  switch_index;
		logic [2:0]  event_kind;
		logic [31:0] press_time;
		logic        last;
	} out_item_t;

	typedef enum logic [2:0] {
		EV_PRESS   = 3'd0,
		EV_SHORT   = 3'd1,
		EV_RELEASE = 3'd2,
		EV_HOLD    = 3'd3,
		EV_REPEAT  = 3'd4
	} event_kind_t;

	typedef enum logic [1:0] {
		CFG_SWITCH_COUNT = 2'd0,
		CFG_REPEAT_MASK  = 2'd1,
		CFG_HOLD_TIME    = 2'd2,
		CFG_REPEAT_TIME  = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_SECOND,
		ST_FLUSH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic init;
		logic scan;
		logic second;
		logic flush;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic last_sw;
		logic second_pend;
		logic push_block;
		logic pend_valid;
	} sts_t;

	localparam logic [3:0]  SWITCH_COUNT_RST = 4'd8;
	localparam logic [7:0]  REPEAT_MASK_RST  = 8'd0;
	localparam logic [31:0] HOLD_TIME_RST    = 32'd500000;
	localparam logic [31:0] REPEAT_TIME_RST  = 32'd100000;
	localparam logic [4:0]  MAX_EVENTS       = 5'd16;

endpackage

/* hdl/sdhr_ctrl.sv */
// sdhr_ctrl: controller state machine for the switch debounce block
// sequences init, per-switch scan, release follow-up and final flush
// depends on sdhr_pkg
module sdhr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_func,
	input  sdhr_pkg::sts_t  sts,
	output logic            in_ready,
	output sdhr_pkg::cmd_t  cmd
);

	sdhr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdhr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			sdhr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_func) begin
						state_d = sdhr_pkg::ST_INIT;
					end else if (sts.cnt_zero) begin
						state_d = sdhr_pkg::ST_FLUSH;
					end else begin
						state_d = sdhr_pkg::ST_SCAN;
					end
				end
			end
			sdhr_pkg::ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = sdhr_pkg::ST_IDLE;
			end
			sdhr_pkg::ST_SCAN: begin
				// wait while a pending event has nowhere to go
				if (!sts.push_block) begin
					cmd.scan = 1'b1;
					if (sts.second_pend) begin
						state_d = sdhr_pkg::ST_SECOND;
					end else if (sts.last_sw) begin
						state_d = sdhr_pkg::ST_FLUSH;
					end
				end
			end
			sdhr_pkg::ST_SECOND: begin
				if (!sts.push_block) begin
					cmd.second = 1'b1;
					state_d    = sts.last_sw ? sdhr_pkg::ST_FLUSH : sdhr_pkg::ST_SCAN;
				end
			end
			sdhr_pkg::ST_FLUSH: begin
				if (!sts.push_block) begin
					cmd.flush = sts.pend_valid;
					state_d   = sdhr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sdhr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* hdl/sdhr_dp.sv */
// sdhr_dp: datapath for the switch debounce block
// per-switch state, config registers, vote and deadline logic, event pending and output registers
// depends on sdhr_pkg
module sdhr_dp #(
	parameter int NUM_SWITCHES   = 8,
	parameter int HISTORY_BITS   = 5,
	parameter int VOTE_THRESHOLD = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sdhr_pkg::cmd_t       cmd,
	output sdhr_pkg::sts_t       sts,
	input  sdhr_pkg::in_item_t   in_data,
	input  logic                 cfg_valid,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 out_ready,
	output logic                 out_valid,
	output sdhr_pkg::out_item_t  out_data
);

	localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
	localparam int ONES_W = $clog2(HISTORY_BITS + 1);

	// configuration
	logic [3:0]  sw_cnt_q;
	logic [7:0]  rep_mask_q;
	logic [31:0] hold_time_q;
	logic [31:0] rep_time_q;

	// per-switch state
	logic [HISTORY_BITS-1:0] hist_q     [NUM_SWITCHES];
	logic                    deb_q      [NUM_SWITCHES];
	logic                    lock_q     [NUM_SWITCHES];
	logic                    hold_sent_q[NUM_SWITCHES];
	logic [31:0]             stamp_q    [NUM_SWITCHES];
	logic [31:0]             deadline_q [NUM_SWITCHES];

	// captured item and walk control
	logic [7:0]       mask_q;
	logic [31:0]      now_q;
	logic [IDX_W-1:0] idx_q;
	logic [4:0]       n_q;

	// one-deep pending event, so the final one can be marked last
	logic                 pend_valid_q;
	sdhr_pkg::out_item_t  pend_q;
	logic                 out_valid_q;
	sdhr_pkg::out_item_t  out_q;

	logic [31:0]             cnt32;
	logic [31:0]             idx_ext;
	logic                    mask_bit;
	logic                    rep_bit;
	logic [HISTORY_BITS-1:0] hist_new;
	logic [ONES_W-1:0]       ones;
	logic                    d;
	logic                    chg;
	logic [31:0]             diff;
	logic                    press, rel, due, hold_ev, rep_ev;
	logic                    push_en;
	sdhr_pkg::event_kind_t   push_kind;
	logic [31:0]             push_stamp;
	logic                    push_ok;
	logic                    out_free;

	always_comb begin
		cnt32 = ({28'd0, sw_cnt_q} > 32'(NUM_SWITCHES)) ? 32'(NUM_SWITCHES) : {28'd0, sw_cnt_q};
		idx_ext  = 32'(idx_q);
		mask_bit = (idx_ext < 32'd8) ? mask_q[idx_ext[2:0]] : 1'b0;
		rep_bit  = (idx_ext < 32'd8) ? rep_mask_q[idx_ext[2:0]] : 1'b0;
		hist_new = HISTORY_BITS'({hist_q[idx_q], mask_bit});
		ones = '0;
		for (int b = 0; b < HISTORY_BITS; b++) begin
			ones = ones + ONES_W'(hist_new[b]);
		end
		d   = (32'(ones) >= 32'(VOTE_THRESHOLD));
		chg = (d != deb_q[idx_q]);
		// signed wrap-around deadline test
		diff    = now_q - deadline_q[idx_q];
		press   = chg && d && !lock_q[idx_q];
		rel     = chg && !d && !lock_q[idx_q];
		due     = !chg && deb_q[idx_q] && !lock_q[idx_q] && !diff[31];
		hold_ev = due && !hold_sent_q[idx_q];
		rep_ev  = due && hold_sent_q[idx_q] && rep_bit;

		push_en    = 1'b0;
		push_kind  = sdhr_pkg::EV_PRESS;
		push_stamp = stamp_q[idx_q];
		if (cmd.second) begin
			push_en   = 1'b1;
			push_kind = sdhr_pkg::EV_RELEASE;
		end else if (cmd.scan) begin
			if (press) begin
				push_en    = 1'b1;
				push_kind  = sdhr_pkg::EV_PRESS;
				push_stamp = now_q;
			end else if (rel) begin
				push_en   = !hold_sent_q[idx_q];
				push_kind = sdhr_pkg::EV_SHORT;
			end else if (hold_ev) begin
				push_en   = 1'b1;
				push_kind = sdhr_pkg::EV_HOLD;
			end else if (rep_ev) begin
				push_en   = 1'b1;
				push_kind = sdhr_pkg::EV_REPEAT;
			end
		end
		// events past the cap are dropped
		push_ok  = push_en && (n_q < sdhr_pkg::MAX_EVENTS);
		out_free = !out_valid_q || out_ready;

		sts.cnt_zero    = (cnt32 == 32'd0);
		sts.last_sw     = ((idx_ext + 32'd1) == cnt32);
		sts.second_pend = rel;
		sts.push_block  = pend_valid_q && !out_free;
		sts.pend_valid  = pend_valid_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_cnt_q    <= sdhr_pkg::SWITCH_COUNT_RST;
			rep_mask_q  <= sdhr_pkg::REPEAT_MASK_RST;
			hold_time_q <= sdhr_pkg::HOLD_TIME_RST;
			rep_time_q  <= sdhr_pkg::REPEAT_TIME_RST;
		end else if (cfg_valid) begin
			unique case (sdhr_pkg::cfg_index_t'(cfg_index))
				sdhr_pkg::CFG_SWITCH_COUNT: sw_cnt_q    <= cfg_data[3:0];
				sdhr_pkg::CFG_REPEAT_MASK:  rep_mask_q  <= cfg_data[7:0];
				sdhr_pkg::CFG_HOLD_TIME:    hold_time_q <= cfg_data;
				sdhr_pkg::CFG_REPEAT_TIME:  rep_time_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-switch state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_SWITCHES; j++) begin
				hist_q[j]      <= '0;
				deb_q[j]       <= 1'b0;
				lock_q[j]      <= 1'b0;
				hold_sent_q[j] <= 1'b0;
				stamp_q[j]     <= '0;
				deadline_q[j]  <= '0;
			end
		end else if (cmd.init) begin
			for (int j = 0; j < NUM_SWITCHES; j++) begin
				if (32'(j) < cnt32) begin
					if ((j < 8) && mask_q[j % 8]) begin
						hist_q[j] <= '1;
						deb_q[j]  <= 1'b1;
						lock_q[j] <= 1'b1;
					end else begin
						hist_q[j] <= '0;
						deb_q[j]  <= 1'b0;
						lock_q[j] <= 1'b0;
					end
					hold_sent_q[j] <= 1'b0;
					stamp_q[j]     <= '0;
					deadline_q[j]  <= '0;
				end
			end
		end else if (cmd.scan) begin
			hist_q[idx_q] <= hist_new;
			if (chg) begin
				deb_q[idx_q] <= d;
				if (lock_q[idx_q] && !d) begin
					lock_q[idx_q] <= 1'b0;
				end
			end
			if (press) begin
				stamp_q[idx_q]     <= now_q;
				deadline_q[idx_q]  <= now_q + hold_time_q;
				hold_sent_q[idx_q] <= 1'b0;
			end
			if (hold_ev) begin
				hold_sent_q[idx_q] <= 1'b1;
			end
			if (hold_ev || rep_ev) begin
				deadline_q[idx_q] <= deadline_q[idx_q] + rep_time_q;
			end
		end
	end

	// captured item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mask_q <= in_data.down_mask;
			now_q  <= in_data.now_us;
		end
	end

	// walk index and event count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			n_q   <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
			n_q   <= '0;
		end else begin
			if ((cmd.scan && !rel) || cmd.second) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (push_ok) begin
				n_q <= n_q + 5'd1;
			end
		end
	end

	// pending event and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push_ok) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if ((push_ok && pend_valid_q) || (!push_ok && cmd.flush)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			pend_q.switch_index <= idx_ext[2:0];
			pend_q.event_kind   <= push_kind;
			pend_q.press_time   <= push_stamp;
			pend_q.last         <= 1'b0;
			if (pend_valid_q) begin
				out_q <= pend_q;
			end
		end else if (cmd.flush) begin
			out_q.switch_index <= pend_q.switch_index;
			out_q.event_kind   <= pend_q.event_kind;
			out_q.press_time   <= pend_q.press_time;
			out_q.last         <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* hdl/switch_debounce_hold_repeat_top.sv */
// switch_debounce_hold_repeat_top: an init item is accepted, then applied in the init state;
// a poll is accepted, scans each switch with an extra step per release, and ends in a flush,
// paced by the single shared per-switch evaluation path; output stalls lengthen the walk.
// one item at a time; the last event leaves through the output register after the walk.
// arst_n clears all switch state and loads the register defaults.
// depends on sdhr_pkg, sdhr_ctrl, sdhr_dp
module switch_debounce_hold_repeat_top #(
	parameter int NUM_SWITCHES   = 8,
	parameter int HISTORY_BITS   = 5,
	parameter int VOTE_THRESHOLD = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sdhr_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sdhr_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	sdhr_pkg::cmd_t cmd;
	sdhr_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	sdhr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_func  (in_data.func),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	sdhr_dp #(
		.NUM_SWITCHES   (NUM_SWITCHES),
		.HISTORY_BITS   (HISTORY_BITS),
		.VOTE_THRESHOLD (VOTE_THRESHOLD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// a new transaction never starts with an event still pending
	a_accept_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !sts.pend_valid)
		else $error("transaction accepted with event pending");

	// flush always presents a last-marked event next cycle
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> out_valid && out_data.last)
		else $error("flush did not present last event");

	// init produces no events
	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init |-> !sts.pend_valid && !cmd.scan && !cmd.second)
		else $error("init overlapped event generation");

endmodule

/* sim/sdhr_event_checker.sv */
`timescale 1ns / 100ps
// sdhr_event_checker: watches the poll, event and register channels of the switch debounce block,
// predicts the event stream from its own copy of switch state and registers, and counts mismatches
// depends on sdhr_pkg
module sdhr_event_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  sdhr_pkg::in_item_t   in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  sdhr_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   fail_count,
	output int                   events_pending
);

	localparam int SWITCHES  = 8;
	localparam int HIST_W    = 5;
	localparam int VOTES     = 3;
	localparam int EVENT_CAP = 16;

	// register copy
	logic [3:0]  sw_count;
	logic [7:0]  rep_mask;
	logic [31:0] hold_us;
	logic [31:0] rep_us;

	// per switch state
	logic [HIST_W-1:0] hist     [SWITCHES];
	logic              deb      [SWITCHES];
	logic              locked   [SWITCHES];
	logic              held     [SWITCHES];
	logic [31:0]       stamp    [SWITCHES];
	logic [31:0]       deadline [SWITCHES];

	sdhr_pkg::out_item_t poll_events [EVENT_CAP];
	int                  poll_count;
	sdhr_pkg::out_item_t expected_events [$];
	sdhr_pkg::out_item_t want;

	// events past the cap are dropped, state still moves on
	task automatic note_event(input int idx, input sdhr_pkg::event_kind_t kind);
		if (poll_count < EVENT_CAP) begin
			poll_events[poll_count].switch_index = 3'(idx);
			poll_events[poll_count].event_kind   = kind;
			poll_events[poll_count].press_time   = stamp[idx];
			poll_events[poll_count].last         = 1'b0;
			poll_count++;
		end
	endtask

	task automatic predict_events(input sdhr_pkg::in_item_t item);
		int          active;
		logic        down;
		logic [31:0] slack;
		poll_count = 0;
		active = (sw_count > SWITCHES) ? SWITCHES : int'(sw_count);
		if (item.func) begin
			for (int i = 0; i < active; i++) begin
				hist[i]     = item.down_mask[i] ? '1 : '0;
				deb[i]      = item.down_mask[i];
				locked[i]   = item.down_mask[i];
				held[i]     = 1'b0;
				stamp[i]    = '0;
				deadline[i] = '0;
			end
		end else begin
			for (int i = 0; i < active; i++) begin
				hist[i] = {hist[i][HIST_W-2:0], item.down_mask[i]};
				down = ($countones(hist[i]) >= VOTES);
				if (down != deb[i]) begin
					deb[i] = down;
					if (locked[i]) begin
						// switch held at init: silent until it goes up
						if (!down)
							locked[i] = 1'b0;
					end else if (down) begin
						stamp[i]    = item.now_us;
						deadline[i] = item.now_us + hold_us;
						held[i]     = 1'b0;
						note_event(i, sdhr_pkg::EV_PRESS);
					end else begin
						if (!held[i])
							note_event(i, sdhr_pkg::EV_SHORT);
						note_event(i, sdhr_pkg::EV_RELEASE);
					end
				end else if (deb[i] && !locked[i]) begin
					// signed wrap-around deadline test
					slack = item.now_us - deadline[i];
					if (!slack[31]) begin
						if (!held[i]) begin
							held[i] = 1'b1;
							note_event(i, sdhr_pkg::EV_HOLD);
							deadline[i] = deadline[i] + rep_us;
						end else if (rep_mask[i]) begin
							note_event(i, sdhr_pkg::EV_REPEAT);
							deadline[i] = deadline[i] + rep_us;
						end
					end
				end
			end
			for (int k = 0; k < poll_count; k++) begin
				poll_events[k].last = (k == poll_count - 1);
				expected_events.push_back(poll_events[k]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_count = sdhr_pkg::SWITCH_COUNT_RST;
			rep_mask = sdhr_pkg::REPEAT_MASK_RST;
			hold_us  = sdhr_pkg::HOLD_TIME_RST;
			rep_us   = sdhr_pkg::REPEAT_TIME_RST;
			for (int i = 0; i < SWITCHES; i++) begin
				hist[i]     = '0;
				deb[i]      = 1'b0;
				locked[i]   = 1'b0;
				held[i]     = 1'b0;
				stamp[i]    = '0;
				deadline[i] = '0;
			end
			expected_events.delete();
			fail_count     = 0;
			events_pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (sdhr_pkg::cfg_index_t'(cfg_index))
					sdhr_pkg::CFG_SWITCH_COUNT: sw_count = cfg_data[3:0];
					sdhr_pkg::CFG_REPEAT_MASK:  rep_mask = cfg_data[7:0];
					sdhr_pkg::CFG_HOLD_TIME:    hold_us  = cfg_data;
					sdhr_pkg::CFG_REPEAT_TIME:  rep_us   = cfg_data;
					default: ;
				endcase
			end
			// an event leaving now belongs to an earlier poll, so compare before predicting
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					$display("%0t ns: unexpected event idx=%0d kind=%0d press=%h last=%b", $time,
						out_data.switch_index, out_data.event_kind, out_data.press_time,
						out_data.last);
					fail_count++;
				end else begin
					want = expected_events.pop_front();
					if (out_data.switch_index !== want.switch_index ||
							out_data.event_kind !== want.event_kind ||
							out_data.press_time !== want.press_time ||
							out_data.last !== want.last) begin
						$display("%0t ns: event mismatch exp idx=%0d kind=%0d press=%h last=%b",
							$time, want.switch_index, want.event_kind, want.press_time, want.last);
						$display("%0t ns:                got idx=%0d kind=%0d press=%h last=%b",
							$time, out_data.switch_index, out_data.event_kind,
							out_data.press_time, out_data.last);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_events(in_data);
			events_pending = expected_events.size();
		end
	end

endmodule

/* sim/tb_switch_debounce_hold_repeat_top.sv */
`timescale 1ns / 100ps
// tb_switch_debounce_hold_repeat_top: stimulus and verdict for the switch debounce block
// drives bouncing switch patterns, inits and register phases; depends on sdhr_pkg, the block
// and sdhr_event_checker
module tb_switch_debounce_hold_repeat_top;

	localparam int DRAIN_CYCLES = 40;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	sdhr_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	sdhr_pkg::out_item_t out_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = '0;
	logic [31:0]         cfg_data = '0;
	int                  fail_count;
	int                  events_pending;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_off_left = 0;
	int          step_max = 1000;
	logic [31:0] clock_us = '0;
	logic [7:0]  sw_level = '0;

	always #1 clk = ~clk;

	switch_debounce_hold_repeat_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sdhr_event_checker event_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.events_pending (events_pending)
	);

	// event receiver: random stalls, or a counted hold-off when requested
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				out_ready = 1'b0;
				hold_off_left--;
			end else begin
				out_ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic sdhr_pkg::in_item_t make_item(input logic func, input logic [7:0] mask,
			input logic [31:0] now);
		sdhr_pkg::in_item_t item;
		item.func      = func;
		item.down_mask = mask;
		item.now_us    = now;
		return item;
	endfunction

	// called just after a falling edge, returns just after one; valid stays up for the caller
	task automatic send_item(input sdhr_pkg::in_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = item;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (events_pending != 0)
			@(negedge clk);
		// polls with no events may still be walking the switches
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input sdhr_pkg::cfg_index_t idx, input logic [31:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// mostly bouncing versions of a slowly changing switch pattern, some inits and raw noise
	task automatic random_item(output sdhr_pkg::in_item_t item);
		int         pick;
		logic [7:0] bounce;
		pick   = $urandom_range(99);
		bounce = '0;
		for (int i = 0; i < 8; i++) begin
			if ($urandom_range(99) < 8)
				sw_level[i] = ~sw_level[i];
			if ($urandom_range(99) < 10)
				bounce[i] = 1'b1;
		end
		clock_us = clock_us + $urandom_range(step_max);
		if (pick < 2)
			clock_us = clock_us + $urandom;
		item = make_item(1'b0, sw_level ^ bounce, clock_us);
		if (pick >= 95)
			item = make_item(1'b1, 8'($urandom), $urandom);
		else if (pick >= 90)
			item.down_mask = 8'($urandom);
	endtask

	task automatic run_phase(input logic [3:0] count, input logic [7:0] rmask,
			input logic [31:0] hold, input logic [31:0] rep, input int step,
			input int send_pct, input int recv_pct, input int n_items, input bit squeeze);
		sdhr_pkg::in_item_t item;
		wait_drained();
		write_reg(sdhr_pkg::CFG_SWITCH_COUNT, {28'd0, count});
		write_reg(sdhr_pkg::CFG_REPEAT_MASK, {24'd0, rmask});
		write_reg(sdhr_pkg::CFG_HOLD_TIME, hold);
		write_reg(sdhr_pkg::CFG_REPEAT_TIME, rep);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		step_max       = step;
		clock_us       = $urandom;
		sw_level       = '0;
		for (int k = 0; k < n_items; k++) begin
			if (squeeze && k == 20)
				hold_off_left = 300;
			if (k == n_items / 2)
				wait_drained();
			random_item(item);
			send_item(item);
		end
	endtask

	initial begin
		logic [31:0] t;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset register values; polls on the reset state, then all eight pressed together
		t = 32'd0;
		send_item(make_item(1'b0, 8'h00, t));
		repeat (3) begin
			t = t + 10;
			send_item(make_item(1'b0, 8'hFF, t));
		end
		// switches 0 and 7 down at init stay locked until released
		send_item(make_item(1'b1, 8'h81, 32'hFFFF_FFFF));
		// switch 1 pressed just below the wrap, its hold deadline lands past zero
		t = 32'hFFFF_F000;
		repeat (4) begin
			send_item(make_item(1'b0, 8'h83, t));
			t = t + 32'h100;
		end
		t = 32'h0008_0000;
		send_item(make_item(1'b0, 8'h83, t));
		repeat (3) begin
			t = t + 1000;
			send_item(make_item(1'b0, 8'h02, t));
		end
		repeat (3) begin
			t = t + 1000;
			send_item(make_item(1'b0, 8'h06, t));
		end
		// release after hold on switch 1, short press on switch 2
		repeat (3) begin
			t = t + 1000;
			send_item(make_item(1'b0, 8'h00, t));
		end
		// full press then full release: sixteen events in one poll
		repeat (3) begin
			t = t + 1000;
			send_item(make_item(1'b0, 8'hFF, t));
		end
		repeat (3) begin
			t = t + 1000;
			send_item(make_item(1'b0, 8'h00, t));
		end

		run_phase(4'd8,  8'hFF, 32'd3000,       32'd1000,       800,  0,  0,  80, 1'b1);
		run_phase(4'd15, 8'hA5, 32'd0,          32'd0,          500,  53, 0,  80, 1'b0);
		run_phase(4'd3,  8'h5A, 32'd5000,       32'd2000,       1500, 0,  53, 80, 1'b0);
		run_phase(4'd0,  8'h00, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1000, 36, 36, 30, 1'b0);
		run_phase(4'd8,  8'h00, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1000, 0,  0,  80, 1'b0);
		run_phase(4'd1,  8'h01, 32'd2500,       32'd700,        600,  0,  53, 60, 1'b0);
		run_phase(4'd8,  8'($urandom), 32'd4000, 32'd1500,      1000, 36, 36, 80, 1'b0);

		wait_drained();
		if (fail_count == 0 && events_pending == 0)
			$display("tb_switch_debounce_hold_repeat_top OK");
		else
			$display("tb_switch_debounce_hold_repeat_top NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_switch_debounce_hold_repeat_top NOT OK");
		$finish;
	end

endmodule

/* switch_debounce_hold_repeat_top.f */
hdl/sdhr_pkg.sv
hdl/sdhr_ctrl.sv
hdl/sdhr_dp.sv
hdl/switch_debounce_hold_repeat_top.sv
sim/sdhr_event_checker.sv
sim/tb_switch_debounce_hold_repeat_top.sv
